// ----- hdl/fvgc_pkg.sv -----
// Shared types and constants for the face geometry coefficient block.
package fvgc_pkg;

    typedef logic [2:0] t_kind;
    typedef logic [1:0] t_axis;
    typedef logic [1:0] t_op;

    localparam t_kind KIND_INTERIOR = 3'd0;
    localparam t_kind KIND_PER_X    = 3'd1;
    localparam t_kind KIND_PER_Y    = 3'd2;
    localparam t_kind KIND_PER_Z    = 3'd3;
    localparam t_kind KIND_HALO     = 3'd4;
    localparam t_kind KIND_BOUNDARY = 3'd5;

    localparam t_axis AXIS_X = 2'd0;
    localparam t_axis AXIS_Y = 2'd1;
    localparam t_axis AXIS_Z = 2'd2;

    localparam t_op OP_PROJ = 2'd0;
    localparam t_op OP_NSQ  = 2'd1;
    localparam t_op OP_LSQ  = 2'd2;
    localparam t_op OP_RSQ  = 2'd3;

    localparam int SUM_W    = 64;
    localparam int COEFF_W  = 31;
    localparam int CORR_W   = 32;
    localparam int WEIGHT_W = 17;
    localparam int ROOT_W   = 32;
    localparam int OUT_W    = 88;
    localparam int WEIGHT_SHIFT = 16;

    localparam logic [COEFF_W-1:0]  COEFF_CAP   = 31'h7fff_ffff;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE  = 17'd65536;
    localparam logic [WEIGHT_W-1:0] WEIGHT_HALF = 17'd32768;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MUL   = 9'b000000010,
        S_ACC   = 9'b000000100,
        S_PREP  = 9'b000001000,
        S_DIVC  = 9'b000010000,
        S_WPREP = 9'b000100000,
        S_DIVW  = 9'b001000000,
        S_CMUL  = 9'b010000000,
        S_CORR  = 9'b100000000
    } t_bstate;

endpackage

// ----- hdl/fvgc_front.sv -----
// Front end: accepts axis beats, resolves the right point and forms the deltas.
module fvgc_front import fvgc_pkg::*; #(
    parameter int CW = 32,
    parameter int IW = 5 * CW,
    parameter int EW = 4 * CW + 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  t_kind         i_kind,
    input  logic [IW-1:0] i_data,
    output logic          o_push,
    input  logic          i_full,
    output logic [EW-1:0] o_entry
);

    t_axis r_axis, n_axis;
    t_kind r_kind, n_kind;
    t_kind kind_now;
    logic  accept;

    logic signed [CW-1:0] left, nb, sh, nrm, fc;
    logic signed [CW:0]   right, d, dl, dr;
    logic signed [CW+1:0] dw, drw;

    assign left = i_data[CW-1:0];
    assign nb   = i_data[2*CW-1:CW];
    assign sh   = i_data[3*CW-1:2*CW];
    assign nrm  = i_data[4*CW-1:3*CW];
    assign fc   = i_data[5*CW-1:4*CW];

    assign o_ready  = !i_full;
    assign accept   = i_valid && !i_full;
    assign o_push   = accept;
    assign kind_now = (r_axis == AXIS_X) ? i_kind : r_kind;

    always_comb begin
        case (kind_now) inside
            KIND_INTERIOR, KIND_HALO: begin
                right = (CW+1)'(nb);
            end
            KIND_PER_X, KIND_PER_Y, KIND_PER_Z: begin
                if ({1'b0, r_axis} == kind_now - 3'd1) begin
                    right = (CW+1)'(nb) + (CW+1)'(sh);
                end else begin
                    right = (CW+1)'(nb);
                end
            end
            default: begin
                right = (CW+1)'(fc);
            end
        endcase
        dw  = (CW+2)'(right) - (CW+2)'(left);
        drw = (CW+2)'(right) - (CW+2)'(fc);
        dl  = (CW+1)'(fc) - (CW+1)'(left);
        if (dw[CW+1] != dw[CW]) begin
            d = dw[CW+1] ? {1'b1, {CW{1'b0}}} : {1'b0, {CW{1'b1}}};
        end else begin
            d = dw[CW:0];
        end
        if (drw[CW+1] != drw[CW]) begin
            dr = drw[CW+1] ? {1'b1, {CW{1'b0}}} : {1'b0, {CW{1'b1}}};
        end else begin
            dr = drw[CW:0];
        end
    end

    assign o_entry = {kind_now, r_axis, d, dl, dr, nrm};

    always_comb begin
        n_axis = r_axis;
        n_kind = r_kind;
        if (accept) begin
            n_kind = kind_now;
            n_axis = (r_axis == AXIS_Z) ? AXIS_X : r_axis + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis <= AXIS_X;
            r_kind <= KIND_INTERIOR;
        end else begin
            r_axis <= n_axis;
            r_kind <= n_kind;
        end
    end

endmodule

// ----- hdl/fvgc_fifo.sv -----
// Two-entry queue between the front and back ends.
module fvgc_fifo #(
    parameter int W = 136
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt != 2'd2))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != 2'd0))
        else $error("queue pop while empty");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + 2'd1))
        else $error("queue count did not advance");

endmodule

// ----- hdl/fvgc_isqrt.sv -----
// Bit-pair iterative floor square root of a 64-bit value.
module fvgc_isqrt import fvgc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SUM_W-1:0]  i_val,
    output logic [ROOT_W-1:0] o_root
);

    logic [SUM_W-1:0]  r_v;
    logic [33:0]       r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [5:0]        r_cnt;
    logic              r_busy;
    logic [35:0]       rem2, trial;
    logic              ge;

    assign rem2   = {r_rem, r_v[SUM_W-1:SUM_W-2]};
    assign trial  = {2'b00, r_root, 2'b01};
    assign ge     = (rem2 >= trial);
    assign o_root = r_root;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v    <= i_val;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_v    <= {r_v[SUM_W-3:0], 2'b00};
            r_rem  <= ge ? 34'(rem2 - trial) : rem2[33:0];
            r_root <= {r_root[ROOT_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd31;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd0) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

// ----- hdl/fvgc_back.sv -----
// Back end: accumulates axis products, divides, takes roots and emits results.
module fvgc_back import fvgc_pkg::*; #(
    parameter int CW = 32,
    parameter int FB = 16,
    parameter int EW = 4 * CW + 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [EW-1:0]    i_entry,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata,
    output logic             o_m_tlast
);

    localparam int MW = (CW + 1 > 33) ? CW + 1 : 33;
    localparam int PW = 2 * MW;

    t_bstate r_st;
    t_op     r_sel;
    t_axis   r_axis, r_k;
    t_kind   r_kind;

    logic signed [CW:0]   r_d, r_dl, r_dr;
    logic signed [CW-1:0] r_n;
    logic signed [CW:0]   r_dst [3];
    logic signed [CW-1:0] r_nst [3];

    logic signed [SUM_W-1:0] r_proj;
    logic [SUM_W-1:0]        r_nsq, r_lsq, r_rsq;
    logic [PW-1:0]           r_prod;
    logic                    r_neg, r_zero;
    logic [COEFF_W-1:0]      r_coeff;
    logic [WEIGHT_W-1:0]     r_weight;

    logic [SUM_W-1:0] r_dnum, r_drem, r_ddiv;
    logic [31:0]      r_dq;
    logic             r_dovf;
    logic [6:0]       r_dcnt;
    logic [4:0]       r_dfs;

    logic                 r_ov, r_ozero, r_olast;
    t_axis                r_oaxis;
    logic [COEFF_W-1:0]   r_ocoeff;
    logic [CORR_W-1:0]    r_ocorr;
    logic [WEIGHT_W-1:0]  r_oweight;

    logic [ROOT_W-1:0] root_l, root_r;
    logic              sq_start;

    function automatic logic [CW:0] mag_d(input logic signed [CW:0] v);
        mag_d = v[CW] ? (~v + 1'b1) : v;
    endfunction

    // entry unpack
    t_kind                e_kind;
    t_axis                e_axis;
    logic signed [CW:0]   e_d, e_dl, e_dr;
    logic signed [CW-1:0] e_n;
    assign {e_kind, e_axis, e_d, e_dl, e_dr, e_n} = i_entry;

    assign o_pop    = (r_st == S_IDLE) && !i_empty;
    assign sq_start = (r_st == S_PREP);

    fvgc_isqrt u_sqrt_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_val   (r_lsq),
        .o_root  (root_l)
    );

    fvgc_isqrt u_sqrt_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_val   (r_rsq),
        .o_root  (root_r)
    );

    // shared multiplier operands
    logic [MW-1:0] ma, mb;
    logic          mneg;
    always_comb begin
        ma   = MW'(mag_d((CW+1)'(r_n)));
        mb   = MW'(mag_d(r_d));
        mneg = r_n[CW-1] ^ r_d[CW];
        if (r_st == S_CMUL) begin
            ma   = MW'(r_coeff);
            mb   = MW'(mag_d(r_dst[r_k]));
            mneg = 1'b0;
        end else begin
            case (r_sel)
                OP_PROJ: begin
                    mb = MW'(mag_d(r_d));
                end
                OP_NSQ: begin
                    mb = MW'(mag_d((CW+1)'(r_n)));
                end
                OP_LSQ: begin
                    ma = MW'(mag_d(r_dl));
                    mb = MW'(mag_d(r_dl));
                end
                OP_RSQ: begin
                    ma = MW'(mag_d(r_dr));
                    mb = MW'(mag_d(r_dr));
                end
                default: begin
                    mb = MW'(mag_d(r_d));
                end
            endcase
        end
    end

    // saturated product and accumulations
    logic [SUM_W-1:0]        pu;
    logic signed [SUM_W-1:0] sp;
    logic signed [SUM_W:0]   s65;
    logic signed [SUM_W-1:0] proj_next;
    logic [SUM_W:0]          u65;
    logic [SUM_W-1:0]        usum_next;
    logic [SUM_W-1:0]        uacc;
    always_comb begin
        pu = (|r_prod[PW-1:SUM_W]) ? '1 : r_prod[SUM_W-1:0];
        if (r_neg) begin
            sp = pu[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : (~pu + 1'b1);
        end else begin
            sp = pu[SUM_W-1] ? {1'b0, {(SUM_W-1){1'b1}}} : pu;
        end
        s65 = (SUM_W+1)'(r_proj) + (SUM_W+1)'(sp);
        if (s65[SUM_W] != s65[SUM_W-1]) begin
            proj_next = s65[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                   : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            proj_next = s65[SUM_W-1:0];
        end
        case (r_sel)
            OP_NSQ:  uacc = r_nsq;
            OP_LSQ:  uacc = r_lsq;
            default: uacc = r_rsq;
        endcase
        u65       = {1'b0, uacc} + {1'b0, pu};
        usum_next = u65[SUM_W] ? '1 : u65[SUM_W-1:0];
    end

    // restoring divider step
    logic             dbit, dge, dfeed;
    logic [SUM_W:0]   drem2;
    logic [31:0]      dq_next;
    logic             dovf_next;
    logic [SUM_W-1:0] proj_mag;
    logic [32:0]      dsum;
    always_comb begin
        dfeed     = (r_dcnt >= 7'(r_dfs));
        dbit      = dfeed ? r_dnum[SUM_W-1] : 1'b0;
        drem2     = {r_drem, dbit};
        dge       = (drem2 >= {1'b0, r_ddiv});
        dq_next   = {r_dq[30:0], dge};
        dovf_next = r_dovf | r_dq[31];
        proj_mag  = r_proj[SUM_W-1] ? (~r_proj + 1'b1) : r_proj;
        dsum      = {1'b0, root_l} + {1'b0, root_r};
    end

    // correction
    logic [SUM_W-1:0]        tm;
    logic signed [SUM_W+1:0] term, corr66;
    logic [CORR_W-1:0]       corr;
    logic                    out_free;
    always_comb begin
        tm     = pu >> FB;
        term   = (r_proj[SUM_W-1] ^ r_dst[r_k][CW]) ? -$signed({2'b00, tm})
                                                     : $signed({2'b00, tm});
        corr66 = (SUM_W+2)'(r_nst[r_k]) - term;
        if (corr66[SUM_W+1:CORR_W-1] == '0 || corr66[SUM_W+1:CORR_W-1] == '1) begin
            corr = corr66[CORR_W-1:0];
        end else begin
            corr = corr66[SUM_W+1] ? {1'b1, {(CORR_W-1){1'b0}}}
                                   : {1'b0, {(CORR_W-1){1'b1}}};
        end
        if (r_zero) begin
            corr = '0;
        end
        out_free = !r_ov || i_m_tready;
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            S_IDLE: begin
                if (!i_empty) begin
                    r_kind <= e_kind;
                    r_axis <= e_axis;
                    r_d    <= e_d;
                    r_dl   <= e_dl;
                    r_dr   <= e_dr;
                    r_n    <= e_n;
                    if (e_axis == AXIS_X) begin
                        r_proj <= '0;
                        r_nsq  <= '0;
                        r_lsq  <= '0;
                        r_rsq  <= '0;
                    end
                end
            end
            S_MUL: begin
                r_prod <= ma * mb;
                r_neg  <= mneg;
            end
            S_ACC: begin
                case (r_sel)
                    OP_PROJ: r_proj <= proj_next;
                    OP_NSQ:  r_nsq  <= usum_next;
                    OP_LSQ:  r_lsq  <= usum_next;
                    default: r_rsq  <= usum_next;
                endcase
                if (r_sel == OP_RSQ) begin
                    r_dst[r_axis] <= r_d;
                    r_nst[r_axis] <= r_n;
                end
            end
            S_PREP: begin
                r_zero <= (r_proj == '0);
                r_k    <= AXIS_X;
                if (r_proj == '0) begin
                    r_coeff  <= '0;
                    r_weight <= '0;
                end
                r_dnum <= r_nsq;
                r_ddiv <= proj_mag;
                r_drem <= '0;
                r_dq   <= '0;
                r_dovf <= 1'b0;
                r_dcnt <= 7'(63 + FB);
                r_dfs  <= 5'(FB);
            end
            S_DIVC, S_DIVW: begin
                if (dfeed) begin
                    r_dnum <= {r_dnum[SUM_W-2:0], 1'b0};
                end
                r_drem <= dge ? SUM_W'(drem2 - {1'b0, r_ddiv}) : drem2[SUM_W-1:0];
                r_dq   <= dq_next;
                r_dovf <= dovf_next;
                r_dcnt <= r_dcnt - 7'd1;
                if (r_dcnt == 7'd0) begin
                    if (r_st == S_DIVC) begin
                        r_coeff <= (dovf_next || dq_next[31]) ? COEFF_CAP
                                                              : dq_next[COEFF_W-1:0];
                    end else begin
                        r_weight <= dq_next[WEIGHT_W-1:0];
                    end
                end
            end
            S_WPREP: begin
                if (r_kind >= KIND_BOUNDARY) begin
                    r_weight <= WEIGHT_ONE;
                end else if (dsum == '0) begin
                    r_weight <= WEIGHT_HALF;
                end
                r_dnum <= SUM_W'(root_r);
                r_ddiv <= SUM_W'(dsum);
                r_drem <= '0;
                r_dq   <= '0;
                r_dovf <= 1'b0;
                r_dcnt <= 7'(63 + WEIGHT_SHIFT);
                r_dfs  <= 5'(WEIGHT_SHIFT);
            end
            S_CMUL: begin
                r_prod <= ma * mb;
                r_neg  <= mneg;
            end
            S_CORR: begin
                if (out_free) begin
                    r_oaxis   <= r_k;
                    r_ocoeff  <= r_coeff;
                    r_ocorr   <= corr;
                    r_oweight <= r_weight;
                    r_ozero   <= r_zero;
                    r_olast   <= (r_k == AXIS_Z);
                    r_k       <= r_k + 2'd1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_IDLE;
            r_sel <= OP_PROJ;
            r_ov  <= 1'b0;
        end else begin
            if (r_st == S_CORR && out_free) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
            case (r_st)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_sel <= OP_PROJ;
                        r_st  <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_st <= S_ACC;
                end
                S_ACC: begin
                    if (r_sel == OP_RSQ) begin
                        r_st <= (r_axis == AXIS_Z) ? S_PREP : S_IDLE;
                    end else begin
                        r_sel <= r_sel + 2'd1;
                        r_st  <= S_MUL;
                    end
                end
                S_PREP: begin
                    r_st <= (r_proj == '0) ? S_CMUL : S_DIVC;
                end
                S_DIVC: begin
                    if (r_dcnt == 7'd0) begin
                        r_st <= S_WPREP;
                    end
                end
                S_WPREP: begin
                    if (r_kind >= KIND_BOUNDARY || dsum == '0) begin
                        r_st <= S_CMUL;
                    end else begin
                        r_st <= S_DIVW;
                    end
                end
                S_DIVW: begin
                    if (r_dcnt == 7'd0) begin
                        r_st <= S_CMUL;
                    end
                end
                S_CMUL: begin
                    r_st <= S_CORR;
                end
                S_CORR: begin
                    if (out_free) begin
                        r_st <= (r_k == AXIS_Z) ? S_IDLE : S_CMUL;
                    end
                end
                default: begin
                    r_st <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tlast  = r_olast;
    assign o_m_tdata  = {5'b00000, r_ozero, r_oweight, r_ocorr, r_ocoeff, r_oaxis};

    a_last_on_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_CORR && out_free && r_k == AXIS_Z) |=> (r_ov && r_olast))
        else $error("z result not marked last");
    a_zero_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ozero) |-> (r_ocoeff == '0 && r_ocorr == '0 && r_oweight == '0))
        else $error("zero distance result carries data");
    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_oweight <= WEIGHT_ONE))
        else $error("weight above one");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_st == S_MUL))
        else $error("popped beat not taken into work");

endmodule

// ----- hdl/fv_face_geometry_coeffs.sv -----
// Top level of the face geometry coefficient block.
// Input stream: one beat per axis of a face, x then y then z. tdata holds
// left, neighbor, shift, normal and face coordinates; tuser holds the face
// kind, read on the x beat only. Output stream: three beats per face after
// the z beat, one per axis, tlast on the z beat.
// A front stage resolves the right point and deltas per beat and queues
// them two deep; the back stage accumulates four products through one
// shared multiplier per axis beat. After z it runs a 1 bit per cycle
// divider for the coefficient alongside two square roots, then a divider
// for the weight, then a multiply and a correction step per result beat.
// A zero projected distance or a boundary face skips the divisions it
// does not need.
// Reset (synchronous, active low) empties the queue and returns to the x
// axis. A stalled receiver holds the output register; the back stage waits
// on it and the queue then fills and deasserts tready.
module fv_face_geometry_coeffs import fvgc_pkg::*; #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16,
    localparam int DW = ((5 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    // left, neighbor, shift, normal, face coordinate, zero fill
    input  logic [DW-1:0]    i_s_tdata,
    // face_kind
    input  logic [2:0]       i_s_tuser,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    // axis, coeff, correction, weight_left, zero_distance, zero fill
    output logic [OUT_W-1:0] o_m_tdata,
    output logic             o_m_tlast
);

    localparam int EW = 4 * COORD_WIDTH + 8;

    logic          push, full, pop, empty;
    logic [EW-1:0] f_entry, b_entry;

    fvgc_front #(
        .CW (COORD_WIDTH),
        .IW (5 * COORD_WIDTH),
        .EW (EW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_kind  (i_s_tuser),
        .i_data  (i_s_tdata[5*COORD_WIDTH-1:0]),
        .o_push  (push),
        .i_full  (full),
        .o_entry (f_entry)
    );

    fvgc_fifo #(
        .W (EW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (b_entry),
        .o_empty (empty)
    );

    fvgc_back #(
        .CW (COORD_WIDTH),
        .FB (FRAC_BITS),
        .EW (EW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_entry    (b_entry),
        .i_empty    (empty),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
